@@ hw/rtl/huffman_code_bit_packer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit assertion macros
// shared property wrappers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH

// generic clocked property with reset disable
`define HCBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal holds its value in the cycle after cond
`define HCBP_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

@@ hw/rtl/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

    // field widths
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;

    // code length bound, saturated on load
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // pending partial byte
    localparam int PEND_W = BYTE_W - 1;
    localparam int PCNT_W = 3;

    // bytes per encoded symbol and the left-aligned packing word
    localparam int MAX_BYTES = 4;
    localparam int EMIT_W    = MAX_BYTES * BYTE_W;
    localparam int ALIGN_W   = EMIT_W + BYTE_W;
    localparam int TOT_W     = 6;
    localparam int BCNT_W    = 3;

    localparam int DEF_SYMBOL_COUNT = 256;

    // input item modes
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    // one code table entry
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

    // group of bytes handed to the output stage, first byte in the top bits
    typedef struct packed {
        logic              valid;
        logic [EMIT_W-1:0] data;
        logic [BCNT_W-1:0] cnt;
    } emit_load_t;

endpackage

@@ hw/rtl/hcbp_table.sv @@
// ----------------------------------------------------------------------------
// hcbp_table
// code table memory, one write and one registered read per cycle;
// entries never written read with length zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_table #(
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT,
    parameter int IDX_W        = $clog2(SYMBOL_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  hcbp_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output hcbp_pkg::entry_t     rd_data
);
    import hcbp_pkg::*;

    entry_t                  mem_reg [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] written_reg;
    entry_t                  rd_entry_reg;
    logic                    rd_written_reg;

    // memory array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem_reg[rd_addr];
        end
    end

    // per-entry written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as length zero
    always_comb
    begin
        rd_data.code = rd_entry_reg.code;
        rd_data.len  = rd_written_reg ? rd_entry_reg.len : '0;
    end

endmodule

@@ hw/rtl/hcbp_emit.sv @@
// ----------------------------------------------------------------------------
// hcbp_emit
// output byte stage: holds up to four packed bytes and hands them out
// one beat at a time, marking the final byte of each group
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcbp_pkg::emit_load_t          load,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last
);
    import hcbp_pkg::*;

    logic [EMIT_W-1:0] data_reg, data_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;

    // room for a new group when empty or the final byte leaves now
    assign out_valid = (cnt_reg != '0);
    assign free      = (cnt_reg == '0) || ((cnt_reg == BCNT_W'(1)) && out_ready);
    assign out_byte  = data_reg[EMIT_W-1 -: BYTE_W];
    assign last      = (cnt_reg == BCNT_W'(1));

    // load a group or shift out one beat
    always_comb
    begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (load.valid)
        begin
            data_next = load.data;
            cnt_next  = load.cnt;
        end
        else if (out_valid && out_ready)
        begin
            data_next = data_reg << BYTE_W;
            cnt_next  = cnt_reg - BCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ hw/rtl/huffman_code_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// loads a symbol code table, packs looked-up codes msb first into bytes,
// and pads the partial byte with zeros on a flush
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready mode symbol code_bits   | sink
//          | code_length                               |
//  out     | out_valid out_ready out_byte last         | source
//
// an item enters every cycle while the output stage has room; the table read and
// the item are registered into the packing stage, whose result loads the output
// stage; bytes then leave at one beat per cycle while out_ready is high. an encode
// yields up to four bytes, so the output port sets the sustained rate.
// reset clears the pending bits and the table's written flags at once.
// out_ready low holds the output stage, then the packing stage, then in_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit #(
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last
);
    import hcbp_pkg::*;

    localparam int IDX_W = $clog2(SYMBOL_COUNT);

    logic              accept;
    logic              sym_ok;
    logic              wr_en;
    logic              rd_en;
    entry_t            wr_entry;
    entry_t            rd_entry;
    logic              emit_free;
    emit_load_t        emit_load;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_flush_reg, s1_flush_next;
    logic [PEND_W-1:0] pbits_reg, pbits_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;

    logic [ALIGN_W-1:0] mask;
    logic [ALIGN_W-1:0] acc;
    logic [ALIGN_W-1:0] aligned;
    logic [TOT_W-1:0]   total;
    logic [BYTE_W-1:0]  flush_byte;
    logic               s1_retire;

    // input decode
    assign accept = in_valid && in_ready;
    assign sym_ok = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign wr_en  = accept && (mode == MODE_LOAD) && sym_ok;
    assign rd_en  = accept && (mode == MODE_ENCODE) && sym_ok;

    // saturate the loaded length
    always_comb
    begin
        wr_entry.code = code_bits;
        wr_entry.len  = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
    end

    hcbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (symbol[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (symbol[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // packing stage: join pending bits with the code and left-align the word, or pad the pending bits on a flush
    always_comb
    begin
        mask       = ~({ALIGN_W{1'b1}} << rd_entry.len);
        acc        = (ALIGN_W'(pbits_reg) << rd_entry.len)
                   | (ALIGN_W'(rd_entry.code) & mask);
        total      = TOT_W'(pcnt_reg) + TOT_W'(rd_entry.len);
        aligned    = acc << (TOT_W'(ALIGN_W) - total);
        flush_byte = BYTE_W'(pbits_reg) << (4'(BYTE_W) - 4'(pcnt_reg));

        pbits_next = pbits_reg;
        pcnt_next  = pcnt_reg;
        if (s1_flush_reg)
        begin
            emit_load.data = {flush_byte, {(EMIT_W-BYTE_W){1'b0}}};
            emit_load.cnt  = (pcnt_reg != '0) ? BCNT_W'(1) : '0;
        end
        else
        begin
            emit_load.data = aligned[ALIGN_W-1 -: EMIT_W];
            emit_load.cnt  = BCNT_W'(total >> 3);
        end

        s1_retire       = s1_valid_reg && ((emit_load.cnt == '0) || emit_free);
        emit_load.valid = s1_retire && (emit_load.cnt != '0);

        if (s1_retire)
        begin
            if (s1_flush_reg)
            begin
                pbits_next = '0;
                pcnt_next  = '0;
            end
            else
            begin
                pbits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[PCNT_W-1:0]);
                pcnt_next  = total[PCNT_W-1:0];
            end
        end
    end

    // packing stage occupancy
    assign in_ready = !s1_valid_reg || s1_retire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (accept && (rd_en || (mode == MODE_FLUSH)))
        begin
            s1_valid_next = 1'b1;
            s1_flush_next = (mode == MODE_FLUSH);
        end
        else if (s1_retire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
            pbits_reg    <= '0;
            pcnt_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
            pbits_reg    <= pbits_next;
            pcnt_reg     <= pcnt_next;
        end
    end

    hcbp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

@@ hw/rtl/hcbp_checker.sv @@
// ----------------------------------------------------------------------------
// hcbp_checker
// port-level checks of the bit packer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_unit_assert.svh"

module hcbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last
);

    // a stalled output beat stays offered and unchanged
    `HCBP_ASSERT(a_out_hold_valid, (out_valid && !out_ready) |=> out_valid, "out beat dropped")
    `HCBP_HOLD(a_out_hold_byte, out_valid && !out_ready, {out_byte, last}, "out beat changed")

    // the bytes of one group leave without a gap
    `HCBP_ASSERT(a_group_cont, (out_valid && out_ready && !last) |=> out_valid,
                 "gap inside a byte group")

    // an empty output stage never blocks the input
    `HCBP_ASSERT(a_ready_idle, !out_valid |-> in_ready, "input blocked with output idle")

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);

@@ sim/huffman_code_bit_packer_unit_check.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit_check
// watches both channels of the bit packer, keeps its own copy of the code
// table and the pending partial byte, and compares every output beat with
// the oldest predicted byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_check #(
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
    input  logic                          last,
    output int                            fail_count,
    output int                            bytes_left,
    output int                            bytes_checked
);

    import hcbp_pkg::*;

    localparam int MAX_REPORTS = 20;

    // one predicted output beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    packed_byte_t        packed_byte_q[$];

    // shadow of the code table and the partial byte
    logic [CODE_W-1:0]   code_tab [SYMBOL_COUNT];
    logic [LEN_W-1:0]    len_tab  [SYMBOL_COUNT];
    logic [PEND_W-1:0]   pend_bits;
    logic [PCNT_W-1:0]   pend_cnt;

    // apply one accepted input beat and queue the bytes it produces
    task automatic pack_symbol(input logic [1:0] m, input logic [SYM_W-1:0] sym,
                               input logic [CODE_W-1:0] code,
                               input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] l;
        logic [63:0]      acc;
        int               total;
        packed_byte_t     b;
        case (m)
            MODE_LOAD:
            begin
                if (int'(sym) < SYMBOL_COUNT)
                begin
                    l = (int'(len) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
                    code_tab[sym] = code;
                    len_tab[sym]  = l;
                end
            end
            MODE_ENCODE:
            begin
                if (int'(sym) < SYMBOL_COUNT && len_tab[sym] != 0)
                begin
                    l     = len_tab[sym];
                    acc   = ({57'd0, pend_bits} << l)
                            | ({32'd0, code_tab[sym]} & ((64'd1 << l) - 64'd1));
                    total = int'(pend_cnt) + int'(l);
                    while (total >= BYTE_W)
                    begin
                        b.data = BYTE_W'(acc >> (total - BYTE_W));
                        b.last = (total < 2 * BYTE_W);
                        packed_byte_q.push_back(b);
                        total -= BYTE_W;
                    end
                    pend_cnt  = PCNT_W'(total);
                    pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            MODE_FLUSH:
            begin
                // pad the partial byte with zeros on the right
                if (pend_cnt != 0)
                begin
                    b.data = BYTE_W'({1'b0, pend_bits} << (BYTE_W - int'(pend_cnt)));
                    b.last = 1'b1;
                    packed_byte_q.push_back(b);
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            default:
            begin
                // unused mode, nothing happens
            end
        endcase
    endtask

    // compare output beats first, then predict from the input beat
    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOL_COUNT; i++)
                len_tab[i] = '0;
            pend_bits = '0;
            pend_cnt  = '0;
            packed_byte_q.delete();
            fail_count    = 0;
            bytes_checked = 0;
            bytes_left    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (packed_byte_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                                 $time, out_byte, last);
                end
                else
                begin
                    want = packed_byte_q.pop_front();
                    bytes_checked++;
                    if (out_byte !== want.data)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: out_byte mismatch, expected %02h actual %02h",
                                     $time, want.data, out_byte);
                    end
                    if (last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: last mismatch, expected %0b actual %0b",
                                     $time, want.last, last);
                    end
                end
            end
            if (in_valid && in_ready)
                pack_symbol(mode, symbol, code_bits, code_length);
            bytes_left = packed_byte_q.size();
        end
    end

endmodule

@@ sim/huffman_code_bit_packer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit_tb
// drives table loads, encodes, flushes and ignored beats into the bit packer
// under random idling on both sides, and takes the verdict from the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_tb;

    import hcbp_pkg::*;

    localparam logic [1:0] MODE_IGNORED   = 2'd3;
    localparam int         PHASE_ITEMS    = 115;
    localparam int         HOLDOFF_CYCLES = 80;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         STALL_LIMIT    = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            mode;
    logic [SYM_W-1:0]      symbol;
    logic [CODE_W-1:0]     code_bits;
    logic [LEN_W-1:0]      code_length;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     out_byte;
    logic                  last;

    int                    fail_count;
    int                    bytes_left;
    int                    bytes_checked;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    holdoff_req;
    int                    stall_cycles;
    int                    mode_cnt [4];
    logic [SYM_W-1:0]      code_syms[$];

    huffman_code_bit_packer_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

    huffman_code_bit_packer_unit_check u_pack_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last),
        .fail_count    (fail_count),
        .bytes_left    (bytes_left),
        .bytes_checked (bytes_checked)
    );

    // clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int seen_req;
        int hold_left;
        seen_req  = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (seen_req != holdoff_req)
            begin
                seen_req  = holdoff_req;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles = 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // offer one input beat and hold it until accepted
    task automatic send_beat(input logic [1:0] m, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        symbol      <= sym;
        code_bits   <= code;
        code_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        mode_cnt[m]++;
    endtask

    // sender pause until every predicted byte has left
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bytes_left != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int               ph;
        int               r;
        logic [1:0]       m;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;

        in_valid      = 1'b0;
        mode          = MODE_LOAD;
        symbol        = '0;
        code_bits     = '0;
        code_length   = '0;
        holdoff_req   = 0;
        send_idle_pct = 27;
        recv_idle_pct = 50;
        foreach (mode_cnt[i])
            mode_cnt[i] = 0;

        // reset
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty cases first, then loads covering the length extremes, then encodes and flushes
        send_beat(MODE_ENCODE,  8'h00, 32'h0,         6'd0);
        send_beat(MODE_FLUSH,   8'h00, 32'h0,         6'd0);
        send_beat(MODE_IGNORED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_beat(MODE_LOAD,    8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_beat(MODE_LOAD,    8'h00, 32'h0,         6'd0);
        send_beat(MODE_LOAD,    8'h01, 32'h1,         6'd1);
        send_beat(MODE_LOAD,    8'h02, 32'hA5A5_5A5A, 6'd63);
        send_beat(MODE_LOAD,    8'h03, 32'h5,         6'd3);
        send_beat(MODE_LOAD,    8'h80, 32'h2AAA_AAAA, 6'd33);
        send_beat(MODE_LOAD,    8'h40, 32'hFFFF_FFC3, 6'd8);
        send_beat(MODE_ENCODE,  8'h01, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'hFF, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'h00, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'h02, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'h03, 32'h0,         6'd0);
        send_beat(MODE_FLUSH,   8'h00, 32'h0,         6'd0);
        send_beat(MODE_FLUSH,   8'h00, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'hFF, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'h40, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'h80, 32'h0,         6'd0);
        send_beat(MODE_IGNORED, 8'h00, 32'h0,         6'd0);
        send_beat(MODE_ENCODE,  8'h03, 32'h0,         6'd0);
        send_beat(MODE_FLUSH,   8'hFF, 32'hFFFF_FFFF, 6'd63);
        code_syms = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h80, 8'h40};

        // random phases with swapped idling, then none
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 27 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long receiver hold-off while beats keep coming
                if (i == 40 && ph != 1)
                    holdoff_req++;
                r   = $urandom_range(99);
                sym = SYM_W'($urandom_range(255));
                len = LEN_W'($urandom_range(63));
                if (r < 18)
                begin
                    m = MODE_LOAD;
                    if ($urandom_range(3) != 0)
                        sym = code_syms[$urandom_range(code_syms.size() - 1)];
                    else
                        code_syms.push_back(sym);
                    r = $urandom_range(99);
                    if (r < 8)
                        len = '0;
                    else if (r < 70)
                        len = LEN_W'($urandom_range(12, 1));
                    else if (r < 88)
                        len = LEN_W'($urandom_range(32, 13));
                    else
                        len = LEN_W'($urandom_range(63, 33));
                end
                else if (r < 83)
                begin
                    m = MODE_ENCODE;
                    if ($urandom_range(9) != 0)
                        sym = code_syms[$urandom_range(code_syms.size() - 1)];
                end
                else if (r < 95)
                    m = MODE_FLUSH;
                else
                    m = MODE_IGNORED;
                send_beat(m, sym, $urandom, len);
            end
            wait_drained();
        end

        // let anything stray show up
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d loads, %0d encodes, %0d flushes, %0d ignored beats",
                 mode_cnt[MODE_LOAD], mode_cnt[MODE_ENCODE], mode_cnt[MODE_FLUSH],
                 mode_cnt[MODE_IGNORED]);
        $display("%0d packed bytes checked, %0d mismatches", bytes_checked, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
